/* hdl/nbc_pkg.sv */
// Shared types, codes and sizing constants for the nibble blitter.
package nbc_pkg;

    localparam int LAYER_COUNT   = 2;
    localparam int LAYER_W       = 1;
    localparam int TABLE_ENTRIES = 4096;
    localparam int TABLE_DEPTH   = 2 * TABLE_ENTRIES;
    localparam int TABLE_AW      = $clog2(TABLE_DEPTH);
    localparam int CQ_DEPTH      = 4;
    localparam int CQ_AW         = $clog2(CQ_DEPTH);
    localparam int OQ_DEPTH      = 4;
    localparam int OQ_AW         = $clog2(OQ_DEPTH);

    typedef enum logic [1:0] {
        OP_REG_WRITE   = 2'd0,
        OP_TABLE_WRITE = 2'd1,
        OP_SOURCE      = 2'd2,
        OP_STATUS      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_TABLE  = 2'd0,
        CMD_PIXEL  = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_kind_t;

    localparam logic [3:0] REG_FLAGS     = 4'h0;
    localparam logic [3:0] REG_SPAN_COLS = 4'h8;
    localparam logic [3:0] REG_SPAN_ROWS = 4'h9;
    localparam logic [3:0] REG_COL_LO    = 4'ha;
    localparam logic [3:0] REG_COL_HI    = 4'hb;
    localparam logic [3:0] REG_ROW_LO    = 4'hc;
    localparam logic [3:0] REG_ROW_HI    = 4'hd;

    localparam logic CFG_COLOUR_BANK = 1'b0;
    localparam logic CFG_DRAW_MODE   = 1'b1;

    localparam logic [1:0] DRAW_MODE_RESET = 2'd1;
    localparam logic [1:0] DRAW_MODE_TAG   = 2'd2;

    localparam logic [7:0] STATUS_BUSY        = 8'hff;
    localparam logic [7:0] STATUS_IDLE        = 8'hfe;
    localparam logic [7:0] TRANSPARENT_COLOUR = 8'hff;
    localparam logic [9:0] COL_MIRROR         = 10'h3ff;
    localparam logic [8:0] ROW_MIRROR         = 9'h1ff;

    localparam int FLAG_XDIR  = 0;
    localparam int FLAG_YDIR  = 1;
    localparam int FLAG_TRANS = 3;
    localparam int FLAG_FLIP  = 4;

    localparam logic RESULT_PIXEL  = 1'b0;
    localparam logic RESULT_STATUS = 1'b1;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [TABLE_AW-1:0] addr_a;
        logic [TABLE_AW-1:0] addr_b;
        logic [7:0]          data;
        logic                tag;
        logic                trans;
        logic [9:0]          x_first;
        logic [9:0]          x_second;
        logic [8:0]          row;
        logic                last;
    } cmd_t;

    typedef struct packed {
        logic       kind;
        logic [9:0] x_first;
        logic [9:0] x_second;
        logic [8:0] row;
        logic [8:0] colour_first;
        logic [8:0] colour_second;
        logic       write_first;
        logic       write_second;
        logic       last;
        logic [7:0] read_data;
    } result_t;

endpackage

/* hdl/nbc_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
module nbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hdl/nbc_front.sv */
// Front end: register file, blit walker and the command queue toward the back end.
module nbc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     operation,
    input  logic [3:0]     reg_offset,
    input  logic [7:0]     write_data,
    input  logic           layer,
    input  logic           cfg_write,
    input  logic           cfg_index,
    input  logic [7:0]     cfg_data,
    output logic           cmd_valid,
    output nbc_pkg::cmd_t  cmd,
    input  logic           cmd_take
);
    import nbc_pkg::*;

    logic [5:0] flags_reg     [LAYER_COUNT];
    logic [5:0] flags_next    [LAYER_COUNT];
    logic [8:0] dest_col_reg  [LAYER_COUNT];
    logic [8:0] dest_col_next [LAYER_COUNT];
    logic [8:0] dest_row_reg  [LAYER_COUNT];
    logic [8:0] dest_row_next [LAYER_COUNT];
    logic [7:0] span_cols_reg [LAYER_COUNT];
    logic [7:0] span_cols_next[LAYER_COUNT];
    logic [7:0] span_rows_reg [LAYER_COUNT];
    logic [7:0] span_rows_next[LAYER_COUNT];

    logic [7:0] bank_reg, bank_next;
    logic [1:0] mode_reg, mode_next;

    logic               busy_reg, busy_next;
    logic [LAYER_W-1:0] blayer_reg, blayer_next;
    logic [8:0]         walk_col_reg, walk_col_next;
    logic [8:0]         walk_row_reg, walk_row_next;
    logic [7:0]         cols_left_reg, cols_left_next;
    logic [7:0]         rows_left_reg, rows_left_next;
    logic [8:0]         start_col_reg, start_col_next;
    logic [7:0]         span_latch_reg, span_latch_next;
    logic [5:0]         fl_latch_reg, fl_latch_next;

    cmd_t           q_mem_reg [CQ_DEPTH];
    logic [CQ_AW-1:0] q_wr_reg, q_rd_reg;
    logic [CQ_AW:0]   q_count_reg;

    logic             accept;
    logic [LAYER_W-1:0] l;
    logic             gen;
    cmd_t             new_cmd;
    logic [3:0]       n1, n2;
    logic [8:0]       row_start;

    assign accept = push && !full;
    assign l      = (LAYER_COUNT > 1) ? layer : '0;

    always_comb
    begin
        for (int i = 0; i < LAYER_COUNT; i++)
        begin
            flags_next[i]     = flags_reg[i];
            dest_col_next[i]  = dest_col_reg[i];
            dest_row_next[i]  = dest_row_reg[i];
            span_cols_next[i] = span_cols_reg[i];
            span_rows_next[i] = span_rows_reg[i];
        end
        bank_next       = bank_reg;
        mode_next       = mode_reg;
        busy_next       = busy_reg;
        blayer_next     = blayer_reg;
        walk_col_next   = walk_col_reg;
        walk_row_next   = walk_row_reg;
        cols_left_next  = cols_left_reg;
        rows_left_next  = rows_left_reg;
        start_col_next  = start_col_reg;
        span_latch_next = span_latch_reg;
        fl_latch_next   = fl_latch_reg;
        gen             = 1'b0;
        new_cmd         = '0;
        row_start       = '0;

        // Nibble order follows the latched x direction.
        n1 = fl_latch_reg[FLAG_XDIR] ? write_data[3:0] : write_data[7:4];
        n2 = fl_latch_reg[FLAG_XDIR] ? write_data[7:4] : write_data[3:0];

        if (cfg_write)
        begin
            if (cfg_index == CFG_COLOUR_BANK)
            begin
                bank_next = cfg_data;
            end
            else
            begin
                mode_next = cfg_data[1:0];
            end
        end

        if (accept)
        begin
            case (op_t'(operation))
                OP_REG_WRITE:
                begin
                    case (reg_offset)
                        REG_FLAGS:
                            flags_next[l] = {write_data[7], !write_data[6], write_data[4],
                                             write_data[2:0]};
                        REG_SPAN_COLS: span_cols_next[l] = write_data;
                        REG_SPAN_ROWS: span_rows_next[l] = write_data;
                        REG_COL_LO:    dest_col_next[l]  = {dest_col_reg[l][8], write_data};
                        REG_COL_HI:    dest_col_next[l]  = {write_data[0], dest_col_reg[l][7:0]};
                        REG_ROW_LO:    dest_row_next[l]  = {dest_row_reg[l][8], write_data};
                        REG_ROW_HI:
                        begin
                            row_start        = {write_data[0], dest_row_reg[l][7:0]};
                            dest_row_next[l] = row_start;
                            busy_next        = 1'b1;
                            blayer_next      = l;
                            fl_latch_next    = flags_reg[l];
                            span_latch_next  = span_cols_reg[l];
                            start_col_next   = flags_reg[l][FLAG_XDIR] ? dest_col_reg[l] :
                                               dest_col_reg[l] + {1'b0, span_cols_reg[l]};
                            walk_col_next    = start_col_next;
                            walk_row_next    = flags_reg[l][FLAG_YDIR] ? row_start :
                                               row_start + {1'b0, span_rows_reg[l]};
                            cols_left_next   = span_cols_reg[l];
                            rows_left_next   = span_rows_reg[l];
                        end
                        default: ;
                    endcase
                end
                OP_TABLE_WRITE:
                begin
                    gen            = 1'b1;
                    new_cmd.kind   = CMD_TABLE;
                    new_cmd.addr_a = {l, bank_reg, reg_offset};
                    new_cmd.data   = write_data;
                end
                OP_STATUS:
                begin
                    gen          = 1'b1;
                    new_cmd.kind = CMD_STATUS;
                    new_cmd.data = (reg_offset == REG_FLAGS && !busy_reg) ? STATUS_IDLE
                                                                          : STATUS_BUSY;
                end
                OP_SOURCE:
                begin
                    if (busy_reg)
                    begin
                        gen              = 1'b1;
                        new_cmd.kind     = CMD_PIXEL;
                        new_cmd.addr_a   = {blayer_reg, bank_reg, n1};
                        new_cmd.addr_b   = {blayer_reg, bank_reg, n2};
                        new_cmd.tag      = (mode_reg == DRAW_MODE_TAG) && blayer_reg[0];
                        new_cmd.trans    = fl_latch_reg[FLAG_TRANS];
                        new_cmd.x_first  = {walk_col_reg, 1'b0};
                        new_cmd.x_second = {walk_col_reg, 1'b1};
                        new_cmd.row      = walk_row_reg;
                        if (!fl_latch_reg[FLAG_FLIP])
                        begin
                            new_cmd.x_first  = new_cmd.x_first ^ COL_MIRROR;
                            new_cmd.x_second = new_cmd.x_second ^ COL_MIRROR;
                            new_cmd.row      = new_cmd.row ^ ROW_MIRROR;
                        end
                        if (cols_left_reg != '0)
                        begin
                            cols_left_next = cols_left_reg - 8'd1;
                            walk_col_next  = fl_latch_reg[FLAG_XDIR] ? walk_col_reg + 9'd1
                                                                     : walk_col_reg - 9'd1;
                        end
                        else if (rows_left_reg != '0)
                        begin
                            rows_left_next = rows_left_reg - 8'd1;
                            walk_row_next  = fl_latch_reg[FLAG_YDIR] ? walk_row_reg + 9'd1
                                                                     : walk_row_reg - 9'd1;
                            walk_col_next  = start_col_reg;
                            cols_left_next = span_latch_reg;
                        end
                        else
                        begin
                            busy_next    = 1'b0;
                            new_cmd.last = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAYER_COUNT; i++)
            begin
                flags_reg[i]     <= '0;
                dest_col_reg[i]  <= '0;
                dest_row_reg[i]  <= '0;
                span_cols_reg[i] <= '0;
                span_rows_reg[i] <= '0;
            end
            bank_reg       <= '0;
            mode_reg       <= DRAW_MODE_RESET;
            busy_reg       <= 1'b0;
            blayer_reg     <= '0;
            walk_col_reg   <= '0;
            walk_row_reg   <= '0;
            cols_left_reg  <= '0;
            rows_left_reg  <= '0;
            start_col_reg  <= '0;
            span_latch_reg <= '0;
            fl_latch_reg   <= '0;
        end
        else
        begin
            for (int i = 0; i < LAYER_COUNT; i++)
            begin
                flags_reg[i]     <= flags_next[i];
                dest_col_reg[i]  <= dest_col_next[i];
                dest_row_reg[i]  <= dest_row_next[i];
                span_cols_reg[i] <= span_cols_next[i];
                span_rows_reg[i] <= span_rows_next[i];
            end
            bank_reg       <= bank_next;
            mode_reg       <= mode_next;
            busy_reg       <= busy_next;
            blayer_reg     <= blayer_next;
            walk_col_reg   <= walk_col_next;
            walk_row_reg   <= walk_row_next;
            cols_left_reg  <= cols_left_next;
            rows_left_reg  <= rows_left_next;
            start_col_reg  <= start_col_next;
            span_latch_reg <= span_latch_next;
            fl_latch_reg   <= fl_latch_next;
        end
    end

    // Command queue toward the back end.
    assign full      = (q_count_reg == (CQ_AW+1)'(CQ_DEPTH));
    assign cmd_valid = (q_count_reg != '0);
    assign cmd       = q_mem_reg[q_rd_reg];

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            q_mem_reg[q_wr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            if (gen)
            begin
                q_wr_reg <= q_wr_reg + 1'b1;
            end
            if (cmd_take)
            begin
                q_rd_reg <= q_rd_reg + 1'b1;
            end
            q_count_reg <= q_count_reg + (CQ_AW+1)'(gen) - (CQ_AW+1)'(cmd_take);
        end
    end

endmodule

/* hdl/nbc_back.sv */
// Back end: colour table access, result formatting and the result queue.
module nbc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  nbc_pkg::cmd_t  cmd,
    output logic           cmd_take,
    output logic           empty,
    input  logic           pop,
    output nbc_pkg::result_t result
);
    import nbc_pkg::*;

    logic             room;
    logic             ram_we, ram_re;
    logic [7:0]       rdata_a, rdata_b;
    logic             s1_valid_reg;
    cmd_t             s1_reg;
    result_t          res_new;
    result_t          oq_mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_AW:0]   oq_count_reg;
    logic             oq_pop;

    // Only commands that yield a result need a reserved slot in the result queue.
    assign room     = (oq_count_reg + (OQ_AW+1)'(s1_valid_reg)) < (OQ_AW+1)'(OQ_DEPTH);
    assign cmd_take = cmd_valid && (cmd.kind == CMD_TABLE || room);
    assign ram_we   = cmd_take && cmd.kind == CMD_TABLE;
    assign ram_re   = cmd_take && cmd.kind == CMD_PIXEL;

    nbc_ram #(
        .WIDTH(8),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (cmd.addr_a),
        .wdata  (cmd.data),
        .re     (ram_re),
        .raddr_a(cmd.addr_a),
        .raddr_b(cmd.addr_b),
        .rdata_a(rdata_a),
        .rdata_b(rdata_b)
    );

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd_take && (cmd.kind == CMD_PIXEL || cmd.kind == CMD_STATUS);
        end
    end

    always_comb
    begin
        res_new = '0;
        if (s1_reg.kind == CMD_PIXEL)
        begin
            res_new.kind          = RESULT_PIXEL;
            res_new.x_first       = s1_reg.x_first;
            res_new.x_second      = s1_reg.x_second;
            res_new.row           = s1_reg.row;
            res_new.colour_first  = {s1_reg.tag, rdata_a};
            res_new.colour_second = {s1_reg.tag, rdata_b};
            res_new.write_first   = (rdata_a != TRANSPARENT_COLOUR) || !s1_reg.trans;
            res_new.write_second  = (rdata_b != TRANSPARENT_COLOUR) || !s1_reg.trans;
            res_new.last          = s1_reg.last;
        end
        else
        begin
            res_new.kind      = RESULT_STATUS;
            res_new.read_data = s1_reg.data;
        end
    end

    assign empty  = (oq_count_reg == '0);
    assign oq_pop = pop && !empty;
    assign result = oq_mem_reg[oq_rd_reg];

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            oq_mem_reg[oq_wr_reg] <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            oq_count_reg <= oq_count_reg + (OQ_AW+1)'(s1_valid_reg) - (OQ_AW+1)'(oq_pop);
        end
    end

endmodule

/* hdl/nibble_blitter_clut_draw_top.sv */
// A result item passes the command queue, the table read register and the result queue.
// Throughput: one input transaction per cycle while full is low, set by the walker in the front
// end and the two-read colour table port in the back end.
// Register writes and source bytes while idle yield no result and leave in the accept cycle.
// Reset: rst_n asynchronously clears registers, walker and both queues; draw_mode resets to 1.
// The colour table is not cleared and holds unknown data until written.
module nibble_blitter_clut_draw_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] operation,
    input  logic [3:0] reg_offset,
    input  logic [7:0] write_data,
    input  logic       layer,
    output logic       empty,
    input  logic       pop,
    output logic       kind,
    output logic [9:0] pixel_x_first,
    output logic [9:0] pixel_x_second,
    output logic [8:0] pixel_row,
    output logic [8:0] colour_first,
    output logic [8:0] colour_second,
    output logic       write_first,
    output logic       write_second,
    output logic       blit_last,
    output logic [7:0] read_data,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    import nbc_pkg::*;

    logic    cmd_valid;
    logic    cmd_take;
    cmd_t    cmd;
    result_t result;

    nbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .reg_offset(reg_offset),
        .write_data(write_data),
        .layer     (layer),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    nbc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_take (cmd_take),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    assign kind           = result.kind;
    assign pixel_x_first  = result.x_first;
    assign pixel_x_second = result.x_second;
    assign pixel_row      = result.row;
    assign colour_first   = result.colour_first;
    assign colour_second  = result.colour_second;
    assign write_first    = result.write_first;
    assign write_second   = result.write_second;
    assign blit_last      = result.last;
    assign read_data      = result.read_data;

endmodule

/* hdl/nbc_checker.sv */
// Port-level assertions for the blitter top level and the bind that attaches them.
module nbc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [1:0] operation,
    input  logic [3:0] reg_offset,
    input  logic [7:0] write_data,
    input  logic       layer,
    input  logic       empty,
    input  logic       pop,
    input  logic       kind,
    input  logic [9:0] pixel_x_first,
    input  logic [9:0] pixel_x_second,
    input  logic [8:0] pixel_row,
    input  logic [8:0] colour_first,
    input  logic [8:0] colour_second,
    input  logic       write_first,
    input  logic       write_second,
    input  logic       blit_last,
    input  logic [7:0] read_data,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);
    import nbc_pkg::*;

    // A status transaction carries only the status byte, and that byte is busy or idle.
    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == RESULT_STATUS) |->
            ((read_data == STATUS_BUSY || read_data == STATUS_IDLE) &&
             pixel_x_first == '0 && pixel_row == '0 && colour_first == '0 &&
             !write_first && !write_second && !blit_last))
        else $error("status transaction with bad fields");

    // A pixel pair never carries status data.
    a_pixel_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == RESULT_PIXEL) |-> read_data == '0)
        else $error("pixel transaction with nonzero read data");

    // The two pixels of a pair sit in neighboring columns of one even-aligned pair.
    a_pixel_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == RESULT_PIXEL) |->
            (pixel_x_first[9:1] == pixel_x_second[9:1] &&
             pixel_x_first[0] != pixel_x_second[0] &&
             colour_first[8] == colour_second[8]))
        else $error("pixel pair columns or tags disagree");

    // A waiting result that is not popped stays put.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(kind) && $stable(pixel_x_first) && $stable(colour_first) &&
             $stable(read_data) && $stable(blit_last)))
        else $error("waiting result changed without a pop");

endmodule

bind nibble_blitter_clut_draw_top nbc_checker u_nbc_checker (.*);
